// ===== src/sonar_hex_frame_parser_unit_defines.svh =====
// Assertion macros used by the checker file of the sonar frame parser.
// Depends on i_clk and i_rst_n being visible where the macros are used.
`ifndef SONAR_HEX_FRAME_PARSER_UNIT_DEFINES_SVH
`define SONAR_HEX_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SHFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shfp assertion failed");

// Next-cycle implication, disabled during reset
`define SHFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shfp assertion failed");

`endif

// ===== src/shfp_pkg.sv =====
// Shared constants, types and helper functions of the sonar hex frame parser.
// No dependencies; used by shfp_parser and sonar_hex_frame_parser_unit.
package shfp_pkg;

    localparam int MAX_SENSORS = 13;
    localparam int MAX_POINTS  = 4;

    localparam logic [7:0] TENTHS_MM_PER_INCH = 8'd254;

    // Configuration register indexes
    localparam logic [1:0] CFG_SENSOR_COUNT  = 2'd0;
    localparam logic [1:0] CFG_POINTS        = 2'd1;
    localparam logic [1:0] CFG_RANGE_FLOOR   = 2'd2;
    localparam logic [1:0] CFG_RANGE_CEILING = 2'd3;

    typedef struct packed {
        logic [3:0]  sensor_count;
        logic [2:0]  beam_points;
        logic [15:0] range_floor;
        logic [15:0] range_ceiling;
    } t_cfg;

    // One completed reading, replayed once per beam point
    typedef struct packed {
        logic [15:0] range_value;
        logic [3:0]  sensor_index;
        logic [5:0]  point_base;
        logic [2:0]  points;
        logic [31:0] scan_number;
        logic        last_sensor;
    } t_run;

    // Uppercase hex digit to value; anything else reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'd48 && c <= 8'd57) begin
            v = 4'(c - 8'd48);
        end else if (c >= 8'd65 && c <= 8'd70) begin
            v = 4'(c - 8'd55);
        end
        return v;
    endfunction

endpackage

// ===== src/sonar_hex_frame_parser_unit.sv =====
// Flow: a byte is registered at accept and parsed when it advances, which waits while a
// previous run is still being output; its first point is loaded into the run register at that advance.
// Throughput: one byte per cycle while no run is still being output and i_pt_stall is low; a byte
// that completes an emitted reading holds the input until all of its points (1..4) are taken.
// Reset: synchronous, active low; clears the frame tracker, scan counter, pending items and
// restores register defaults (13 sensors, 1 point, floor 0, ceiling 65535).
module sonar_hex_frame_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received characters
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    // range points
    output logic        o_pt_valid,
    input  logic        i_pt_stall,
    output logic [15:0] o_range_value,
    output logic [3:0]  o_sensor_index,
    output logic [5:0]  o_point_index,
    output logic [31:0] o_scan_number,
    output logic        o_end_of_run,
    output logic        o_end_of_scan,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    shfp_pkg::t_cfg r_cfg;
    shfp_pkg::t_run r_run;
    shfp_pkg::t_run parse_run;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_run_valid;
    logic [1:0] r_rep;

    logic rx_accept;
    logic pt_accept;
    logic rep_last;
    logic run_done;
    logic advance;
    logic parse_emit;

    // Register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sensor_count  <= 4'(shfp_pkg::MAX_SENSORS);
            r_cfg.beam_points   <= 3'd1;
            r_cfg.range_floor   <= 16'd0;
            r_cfg.range_ceiling <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                shfp_pkg::CFG_SENSOR_COUNT:  r_cfg.sensor_count  <= i_cfg_data[3:0];
                shfp_pkg::CFG_POINTS:        r_cfg.beam_points   <= i_cfg_data[2:0];
                shfp_pkg::CFG_RANGE_FLOOR:   r_cfg.range_floor   <= i_cfg_data;
                shfp_pkg::CFG_RANGE_CEILING: r_cfg.range_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake control
    always_comb begin
        rep_last   = ({1'b0, r_rep} + 3'd1) == r_run.points;
        pt_accept  = r_run_valid && !i_pt_stall;
        run_done   = pt_accept && rep_last;
        advance    = r_in_valid && (!r_run_valid || run_done);
        o_rx_stall = r_in_valid && !advance;
        rx_accept  = i_rx_valid && !o_rx_stall;
    end

    // Hold one received item ahead of the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (rx_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    shfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_emit  (parse_emit),
        .o_run   (parse_run)
    );

    // Load a new run or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_rep       <= 2'd0;
        end else if (advance) begin
            r_run_valid <= parse_emit;
            r_rep       <= 2'd0;
        end else if (run_done) begin
            r_run_valid <= 1'b0;
        end else if (pt_accept) begin
            r_rep <= r_rep + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && parse_emit) begin
            r_run <= parse_run;
        end
    end

    // Drive the point outputs
    always_comb begin
        o_pt_valid     = r_run_valid;
        o_range_value  = r_run.range_value;
        o_sensor_index = r_run.sensor_index;
        o_point_index  = r_run.point_base + 6'(r_rep);
        o_scan_number  = r_run.scan_number;
        o_end_of_run   = rep_last;
        o_end_of_scan  = rep_last && r_run.last_sensor;
    end

endmodule

// ===== src/shfp_parser.sv =====
// Header hunt, hex payload decode, scaling and clamping for one byte per cycle while i_fire is high.
// Depends on shfp_pkg.
module shfp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  logic [7:0]     i_byte,
    input  shfp_pkg::t_cfg i_cfg,
    output logic           o_emit,
    output shfp_pkg::t_run o_run
);

    localparam logic [2:0] ST_HUNT    = 3'd0;
    localparam logic [2:0] ST_GOT_A   = 3'd1;
    localparam logic [2:0] ST_GOT_B   = 3'd2;
    localparam logic [2:0] ST_GOT_1   = 3'd3;
    localparam logic [2:0] ST_PAYLOAD = 3'd4;

    localparam logic [4:0] LAST_CHAR = 5'd25;

    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_B   = 8'h42;
    localparam logic [7:0] CH_ONE = 8'h31;
    localparam logic [7:0] CH_TWO = 8'h32;

    logic [2:0]  r_state, n_state;
    logic [4:0]  r_count, n_count;
    logic [3:0]  r_high, n_high;
    logic [31:0] r_scan, n_scan;

    logic [3:0]  cnt_eff;
    logic [2:0]  ppb_eff;
    logic [3:0]  sensor;
    logic [3:0]  low_digit;
    logic [15:0] scaled;
    logic [15:0] clamped;
    logic [2:0]  restart;

    // Effective register values
    always_comb begin
        cnt_eff = (i_cfg.sensor_count > 4'(shfp_pkg::MAX_SENSORS))
                ? 4'(shfp_pkg::MAX_SENSORS) : i_cfg.sensor_count;
        ppb_eff = (i_cfg.beam_points > 3'(shfp_pkg::MAX_POINTS))
                ? 3'(shfp_pkg::MAX_POINTS) : i_cfg.beam_points;
    end

    // Scale inches to tenths of mm and clamp
    always_comb begin
        sensor    = r_count[4:1];
        low_digit = shfp_pkg::hex_value(i_byte);
        scaled    = 16'({r_high, low_digit}) * 16'(shfp_pkg::TENTHS_MM_PER_INCH);
        if (scaled < i_cfg.range_floor) begin
            clamped = i_cfg.range_floor;
        end else if (scaled > i_cfg.range_ceiling) begin
            clamped = i_cfg.range_ceiling;
        end else begin
            clamped = scaled;
        end
    end

    // Describe the run of points for a completed reading
    always_comb begin
        o_emit = (r_state == ST_PAYLOAD) && r_count[0] && (sensor < cnt_eff)
               && (ppb_eff != 3'd0);
        o_run.range_value  = clamped;
        o_run.sensor_index = sensor;
        o_run.point_base   = 6'(sensor) * 6'(ppb_eff);
        o_run.points       = ppb_eff;
        o_run.scan_number  = r_scan;
        o_run.last_sensor  = (5'(sensor) + 5'd1) == 5'(cnt_eff);
    end

    // Next state of the frame tracker
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_high  = r_high;
        n_scan  = r_scan;
        restart = (i_byte == CH_A) ? ST_GOT_A : ST_HUNT;
        unique case (r_state)
            ST_HUNT: begin
                n_state = restart;
            end
            ST_GOT_A: begin
                n_state = (i_byte == CH_B) ? ST_GOT_B : restart;
            end
            ST_GOT_B: begin
                n_state = (i_byte == CH_ONE) ? ST_GOT_1 : restart;
            end
            ST_GOT_1: begin
                if (i_byte == CH_TWO) begin
                    n_state = ST_PAYLOAD;
                    n_count = 5'd0;
                    n_high  = 4'd0;
                end else begin
                    n_state = restart;
                end
            end
            ST_PAYLOAD: begin
                if (!r_count[0]) begin
                    n_high = low_digit;
                end
                if (r_count == LAST_CHAR) begin
                    n_count = 5'd0;
                    n_state = ST_HUNT;
                    n_scan  = r_scan + 32'd1;
                end else begin
                    n_count = r_count + 5'd1;
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // Advance on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_count <= 5'd0;
            r_high  <= 4'd0;
            r_scan  <= 32'd0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_count <= n_count;
            r_high  <= n_high;
            r_scan  <= n_scan;
        end
    end

endmodule

// ===== src/shfp_checker.sv =====
// Port-level checks on the point channel of the sonar frame parser, bound to the top level.
// Depends on sonar_hex_frame_parser_unit_defines.svh.
`include "sonar_hex_frame_parser_unit_defines.svh"

module shfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pt_stall,
    input logic        o_pt_valid,
    input logic [15:0] o_range_value,
    input logic [3:0]  o_sensor_index,
    input logic        o_end_of_run,
    input logic        o_end_of_scan
);

    // A stalled point keeps its value
    `SHFP_ASSERT_NEXT(a_stall_hold, o_pt_valid && i_pt_stall, o_pt_valid && $stable(o_range_value))

    // End of scan only closes a run
    `SHFP_ASSERT_NOW(a_scan_ends_run, o_pt_valid && o_end_of_scan, o_end_of_run)

    // Sensor index stays within the frame
    `SHFP_ASSERT_NOW(a_sensor_range, o_pt_valid, o_sensor_index < 4'd13)

    // A run continues with the same sensor and value until its last point
    `SHFP_ASSERT_NEXT(a_run_continues, o_pt_valid && !i_pt_stall && !o_end_of_run, o_pt_valid && $stable(o_sensor_index) && $stable(o_range_value))

endmodule

bind sonar_hex_frame_parser_unit shfp_checker u_shfp_checker (.*);
